// File: src/dsbc_pkg.sv
// Shared types and constants for the depth sort / back-face cull block.
// No dependencies; imported by every module of the block.
package dsbc_pkg;

  localparam int MAX_TRIS = 64;   // capacity of the cell row, at least 2
  localparam int DEPTH_W  = 16;   // Q1.15 depth fields
  localparam int ID_W     = 16;
  localparam int KEY_W    = DEPTH_W + 2;  // exact sum of three depths

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [ID_W-1:0]         tri_id_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_t;

  // Broadcast from the top level to every cell.
  typedef struct packed {
    cell_op_t op;
    key_t     key;
    tri_id_t  id;
  } cell_ctrl_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic    valid;
    key_t    key;
    tri_id_t id;
  } cell_data_t;

endpackage

// File: src/depth_sort_with_backface_cull.sv
// Depth sort with back-face culling: top level with the cell row and control.
// Depends on dsbc_pkg and dsbc_cell.
//
// Usage
//   Input channel (in_*): one triangle per beat: three Q1.15 vertex depths,
//   the normal depth, an index and a final mark. A triangle with a negative
//   normal depth is dropped. Kept triangles are inserted into a row of
//   MAX_TRIS cells ordered by decreasing depth sum, ties in arrival order.
//   Triangles stream in at one per cycle while in_ready is high.
//   Output channel (out_*): after the beat with the final mark, the indices
//   come out far to near, end_of_list on the last one. The first result is
//   registered once the output register is free in the drain state, then
//   one per cycle while out_ready stays high: N kept triangles give N beats
//   (one beat with none_kept set when nothing was kept). The drain rate is
//   set by the row shifting toward its head once per delivered beat.
//   While draining, in_ready is low; it rises as the last result is loaded.
//   Front-facing triangles beyond capacity are discarded and reported with
//   dropped_some on every result of that run.
//   Receiver stall: the output register holds its beat and the row waits.
//   Reset: row empty, overflow cleared, input ready, no result pending.
module depth_sort_with_backface_cull import dsbc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DEPTH_W-1:0] in_vertex0_depth,
  input  logic signed [DEPTH_W-1:0] in_vertex1_depth,
  input  logic signed [DEPTH_W-1:0] in_vertex2_depth,
  input  logic signed [DEPTH_W-1:0] in_normal_depth,
  input  logic [ID_W-1:0]           in_triangle_id,
  input  logic                      in_final_triangle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ID_W-1:0]           out_sorted_id,
  output logic                      out_none_kept,
  output logic                      out_dropped_some,
  output logic                      out_end_of_list
);

  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } state_t;

  state_t     state_r, state_nxt;
  logic       ovf_r, ovf_nxt;
  logic       out_valid_r;
  tri_id_t    out_id_r;
  logic       out_none_r, out_drop_r, out_end_r;

  cell_ctrl_t ctrl;
  cell_data_t cell_q [MAX_TRIS];
  logic       cell_ge [MAX_TRIS];

  logic       in_acc, front, full, do_ins, drain_load, last_load;

  // ---- input side ---------------------------------------------------------
  assign in_ready = (state_r == ST_FILL);
  assign in_acc   = in_valid && in_ready;
  assign front    = !in_normal_depth[DEPTH_W-1];  // zero normal counts as front
  assign full     = cell_q[MAX_TRIS-1].valid;
  assign do_ins   = in_acc && front && !full;

  // ---- drain side ---------------------------------------------------------
  assign drain_load = (state_r == ST_DRAIN) && (!out_valid_r || out_ready);
  assign last_load  = drain_load && !cell_q[1].valid;

  always_comb begin
    ctrl.key = key_t'(in_vertex0_depth) + key_t'(in_vertex1_depth)
             + key_t'(in_vertex2_depth);
    ctrl.id  = in_triangle_id;
    if (do_ins) begin
      ctrl.op = OP_INSERT;
    end else if (drain_load) begin
      ctrl.op = OP_SHIFT;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  // ---- cell row -----------------------------------------------------------
  for (genvar g = 0; g < MAX_TRIS; g++) begin : g_cell
    cell_data_t prev_d, next_d;
    logic       prev_ge;

    if (g == 0) begin : g_head
      assign prev_d  = '0;
      assign prev_ge = 1'b1;
    end else begin : g_mid
      assign prev_d  = cell_q[g-1];
      assign prev_ge = cell_ge[g-1];
    end

    if (g == MAX_TRIS - 1) begin : g_tail
      assign next_d = '0;
    end else begin : g_body
      assign next_d = cell_q[g+1];
    end

    dsbc_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .prev_i    (prev_d),
      .prev_ge_i (prev_ge),
      .next_i    (next_d),
      .data_o    (cell_q[g]),
      .ge_o      (cell_ge[g])
    );
  end

  // ---- control ------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          if (front && full) begin
            ovf_nxt = 1'b1;
          end
          if (in_final_triangle) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (last_load) begin
          state_nxt = ST_FILL;
          ovf_nxt   = 1'b0;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      if (drain_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload: head cell, or the empty-run marker.
  always_ff @(posedge clk) begin
    if (drain_load) begin
      out_id_r   <= cell_q[0].valid ? cell_q[0].id : '0;
      out_none_r <= !cell_q[0].valid;
      out_drop_r <= ovf_r;
      out_end_r  <= !cell_q[1].valid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_id    = out_id_r;
  assign out_none_kept    = out_none_r;
  assign out_dropped_some = out_drop_r;
  assign out_end_of_list  = out_end_r;

endmodule

// File: src/dsbc_cell.sv
// One slot of the sorted cell row: holds a key and an index.
// Depends on dsbc_pkg.
module dsbc_cell import dsbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_data_t prev_i,    // neighbor toward the head
  input  logic       prev_ge_i, // head neighbor keeps its entry
  input  cell_data_t next_i,    // neighbor toward the tail
  output cell_data_t data_o,
  output logic       ge_o       // this entry stays ahead of the new key
);

  logic    valid_r, valid_nxt;
  key_t    key_r, key_nxt;
  tri_id_t id_r, id_nxt;

  assign ge_o   = valid_r && (key_r >= ctrl.key);
  assign data_o = '{valid: valid_r, key: key_r, id: id_r};

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    id_nxt    = id_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (!ge_o) begin
          if (prev_ge_i) begin
            // new entry lands here
            valid_nxt = 1'b1;
            key_nxt   = ctrl.key;
            id_nxt    = ctrl.id;
          end else begin
            // make room: take the head neighbor's entry
            valid_nxt = prev_i.valid;
            key_nxt   = prev_i.key;
            id_nxt    = prev_i.id;
          end
        end
      end
      OP_SHIFT: begin
        valid_nxt = next_i.valid;
        key_nxt   = next_i.key;
        id_nxt    = next_i.id;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    id_r  <= id_nxt;
  end

endmodule

// File: src/dsbc_checker.sv
// Port-level checks for depth_sort_with_backface_cull, bound to the top level.
// Depends on dsbc_pkg.
module dsbc_checker import dsbc_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_final_triangle,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] out_sorted_id,
  input logic            out_none_kept,
  input logic            out_end_of_list
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sorted_id)
      && $stable(out_end_of_list) && $stable(out_none_kept))
    else $error("result beat changed while stalled");

  // An empty run is a single beat.
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_kept |-> out_end_of_list)
    else $error("none_kept without end_of_list");

  a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_kept |-> out_sorted_id == '0)
    else $error("none_kept with nonzero index");

  // The final beat starts a drain, which blocks input.
  a_drain_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final_triangle |=> !in_ready)
    else $error("input taken right after final beat");

endmodule

bind depth_sort_with_backface_cull dsbc_checker u_dsbc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_final_triangle (in_final_triangle),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_sorted_id     (out_sorted_id),
  .out_none_kept     (out_none_kept),
  .out_end_of_list   (out_end_of_list)
);
